FILE: sv/sawc_pkg.sv
`default_nettype none

package sawc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // request codes
    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_RX    = 2'd1;
    localparam logic [1:0] REQ_TIMER = 2'd2;

    // frame kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_ACK      = 2'd1;
    localparam logic [1:0] KIND_DATA_ACK = 2'd2;
    localparam logic [1:0] KIND_BAD      = 2'd3;

    // timer commands
    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    // x^k mod (x^3 + x^2 + 1), period seven
    localparam logic [2:0] XPOW [0:6] = '{3'b001, 3'b010, 3'b100, 3'b101,
                                          3'b111, 3'b011, 3'b110};

    // remainder contributions of a one in bit 0 of the ack and seq fields
    localparam logic [2:0] CRC_ACK_TERM = 3'b110;
    localparam logic [2:0] CRC_SEQ_TERM = 3'b101;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_SEND  = 2'd1,
        OP_RX    = 2'd2,
        OP_TIMER = 2'd3
    } op_t;

    // classified word handed from front to back
    typedef struct packed {
        op_t         op;
        logic        ack_part;
        logic        data_part;
        logic        data_ack;
        logic        sound;
        logic        ack_is_zero;
        logic        ack_is_one;
        logic        seq_is_zero;
        logic        seq_is_one;
        logic [23:0] payload;
        logic [1:0]  len;
        logic [2:0]  base_crc;
    } entry_t;

    // leading zeros leave the remainder at zero, so the message is right aligned
    function automatic logic [2:0] crc3_word(input logic [43:0] msg);
        logic [2:0] rem;
        rem = '0;
        for (int i = 0; i < 44; i++) begin
            if (msg[i])
                rem = rem ^ XPOW[(i + 3) % 7];
        end
        return rem;
    endfunction

    function automatic logic [23:0] keep_bytes(input logic [23:0] p, input logic [1:0] len);
        logic [23:0] r;
        case (len)
            2'd0:    r = 24'h000000;
            2'd1:    r = p & 24'hFF0000;
            2'd2:    r = p & 24'hFFFF00;
            default: r = p;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] align_bytes(input logic [23:0] p, input logic [1:0] len);
        logic [23:0] r;
        case (len)
            2'd0:    r = 24'h000000;
            2'd1:    r = {16'h0000, p[23:16]};
            2'd2:    r = {8'h00, p[23:8]};
            default: r = p;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/sawc_req_if.sv
`default_nettype none

interface sawc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [23:0] payload_bytes;
    logic [1:0]  payload_len;
    logic [1:0]  rx_kind;
    logic [9:0]  rx_seq;
    logic [9:0]  rx_ack;
    logic [2:0]  rx_crc;

    modport source (output valid, req_type, payload_bytes, payload_len, rx_kind,
                    rx_seq, rx_ack, rx_crc, input ready);
    modport sink (input valid, req_type, payload_bytes, payload_len, rx_kind,
                  rx_seq, rx_ack, rx_crc, output ready);
endinterface

`default_nettype wire

FILE: sv/sawc_rsp_if.sv
`default_nettype none

interface sawc_rsp_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [1:0]  tx_kind;
    logic [9:0]  tx_seq;
    logic [9:0]  tx_ack;
    logic [2:0]  tx_crc;
    logic [23:0] tx_payload;
    logic [1:0]  tx_len;
    logic        deliver_valid;
    logic [23:0] deliver_payload;
    logic [1:0]  deliver_len;
    logic [1:0]  timer_cmd;

    modport source (output valid, tx_valid, tx_kind, tx_seq, tx_ack, tx_crc, tx_payload,
                    tx_len, deliver_valid, deliver_payload, deliver_len, timer_cmd,
                    input ready);
    modport sink (input valid, tx_valid, tx_kind, tx_seq, tx_ack, tx_crc, tx_payload,
                  tx_len, deliver_valid, deliver_payload, deliver_len, timer_cmd,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/sawc_front.sv
`default_nettype none

module sawc_front
    import sawc_pkg::*;
(
    sawc_req_if.sink req,
    input  logic     q_ready,
    output logic     q_push,
    output entry_t   q_entry
);

    logic [23:0] pay;
    logic [23:0] pay_aligned;
    logic [2:0]  rx_rem;

    assign pay         = keep_bytes(req.payload_bytes, req.payload_len);
    assign pay_aligned = align_bytes(pay, req.payload_len);
    assign rx_rem      = crc3_word({pay_aligned, req.rx_ack, req.rx_seq});

    assign req.ready = q_ready;
    assign q_push    = req.valid && q_ready;

    always_comb
    begin
        q_entry = '0;
        unique case (req.req_type)
            REQ_SEND:  q_entry.op = OP_SEND;
            REQ_RX:    q_entry.op = (req.rx_kind == KIND_BAD) ? OP_NONE : OP_RX;
            REQ_TIMER: q_entry.op = OP_TIMER;
            default:   q_entry.op = OP_NONE;
        endcase
        q_entry.ack_part    = (req.rx_kind == KIND_ACK) || (req.rx_kind == KIND_DATA_ACK);
        q_entry.data_part   = (req.rx_kind == KIND_DATA) || (req.rx_kind == KIND_DATA_ACK);
        q_entry.data_ack    = (req.rx_kind == KIND_DATA_ACK);
        q_entry.sound       = (rx_rem == req.rx_crc);
        q_entry.ack_is_zero = (req.rx_ack == 10'd0);
        q_entry.ack_is_one  = (req.rx_ack == 10'd1);
        q_entry.seq_is_zero = (req.rx_seq == 10'd0);
        q_entry.seq_is_one  = (req.rx_seq == 10'd1);
        q_entry.payload     = pay;
        q_entry.len         = req.payload_len;
        // remainder with zero ack and seq; back end folds in its own bits
        q_entry.base_crc    = crc3_word({pay_aligned, 20'd0});
    end

endmodule

`default_nettype wire

FILE: sv/sawc_queue.sv
`default_nettype none

module sawc_queue
    import sawc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t din,
    output logic   not_full,
    input  logic   pop,
    output entry_t dout,
    output logic   not_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_full  = (count_reg != FULL);
    assign not_empty = (count_reg != '0);
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sawc_back.sv
`default_nettype none

module sawc_back
    import sawc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       q_valid,
    input  entry_t     q_entry,
    output logic       q_pop,
    sawc_rsp_if.source rsp
);

    typedef struct packed {
        logic        tx_valid;
        logic [1:0]  tx_kind;
        logic [9:0]  tx_seq;
        logic [9:0]  tx_ack;
        logic [2:0]  tx_crc;
        logic [23:0] tx_payload;
        logic [1:0]  tx_len;
        logic        deliver_valid;
        logic [23:0] deliver_payload;
        logic [1:0]  deliver_len;
        logic [1:0]  timer_cmd;
    } res_t;

    logic        piggy_reg;
    logic        ready_to_send_reg, ready_to_send_next;
    logic        send_seq_reg, send_seq_next;
    logic        recv_ack_reg, recv_ack_next;
    logic        ack_owed_reg, ack_owed_next;
    logic [1:0]  held_kind_reg, held_kind_next;
    logic        held_seq_reg, held_seq_next;
    logic        held_ack_reg, held_ack_next;
    logic [2:0]  held_crc_reg, held_crc_next;
    logic [23:0] held_payload_reg, held_payload_next;
    logic [1:0]  held_len_reg, held_len_next;
    logic        out_valid_reg;
    res_t        out_reg;
    res_t        res_next;

    logic load;
    logic ack_match;
    logic expected;
    logic send_ack;
    logic data_ack_bit;

    assign load  = q_valid && (!out_valid_reg || rsp.ready);
    assign q_pop = load;

    // full ten-bit compares were done in the front end
    assign ack_match = q_entry.sound && (send_seq_reg ? q_entry.ack_is_one : q_entry.ack_is_zero);
    assign expected  = recv_ack_reg ? q_entry.seq_is_zero : q_entry.seq_is_one;

    always_comb
    begin
        res_next           = '0;
        ready_to_send_next = ready_to_send_reg;
        send_seq_next      = send_seq_reg;
        recv_ack_next      = recv_ack_reg;
        ack_owed_next      = ack_owed_reg;
        held_kind_next     = held_kind_reg;
        held_seq_next      = held_seq_reg;
        held_ack_next      = held_ack_reg;
        held_crc_next      = held_crc_reg;
        held_payload_next  = held_payload_reg;
        held_len_next      = held_len_reg;
        send_ack           = 1'b0;
        data_ack_bit       = ack_owed_reg && recv_ack_reg;

        unique case (q_entry.op)
            OP_SEND:
            begin
                if (ready_to_send_reg)
                begin
                    ready_to_send_next = 1'b0;
                    ack_owed_next      = 1'b0;
                    held_kind_next     = ack_owed_reg ? KIND_DATA_ACK : KIND_DATA;
                    held_seq_next      = send_seq_reg;
                    held_ack_next      = data_ack_bit;
                    held_crc_next      = q_entry.base_crc
                                       ^ (data_ack_bit ? CRC_ACK_TERM : 3'b000)
                                       ^ (send_seq_reg ? CRC_SEQ_TERM : 3'b000);
                    held_payload_next  = q_entry.payload;
                    held_len_next      = q_entry.len;
                    res_next.tx_valid   = 1'b1;
                    res_next.tx_kind    = held_kind_next;
                    res_next.tx_seq     = {9'd0, send_seq_reg};
                    res_next.tx_ack     = {9'd0, data_ack_bit};
                    res_next.tx_crc     = held_crc_next;
                    res_next.tx_payload = q_entry.payload;
                    res_next.tx_len     = q_entry.len;
                    res_next.timer_cmd  = TMR_START;
                end
            end
            OP_TIMER:
            begin
                // resend even with nothing outstanding
                held_kind_next      = KIND_DATA;
                res_next.tx_valid   = 1'b1;
                res_next.tx_kind    = KIND_DATA;
                res_next.tx_seq     = {9'd0, held_seq_reg};
                res_next.tx_ack     = {9'd0, held_ack_reg};
                res_next.tx_crc     = held_crc_reg;
                res_next.tx_payload = held_payload_reg;
                res_next.tx_len     = held_len_reg;
                res_next.timer_cmd  = TMR_START;
            end
            OP_RX:
            begin
                if (q_entry.ack_part && ack_match)
                begin
                    ready_to_send_next = 1'b1;
                    send_seq_next      = ~send_seq_reg;
                    res_next.timer_cmd = TMR_STOP;
                end
                if (q_entry.data_part)
                begin
                    if (expected && q_entry.sound)
                    begin
                        recv_ack_next            = ~recv_ack_reg;
                        res_next.deliver_valid   = 1'b1;
                        res_next.deliver_payload = q_entry.payload;
                        res_next.deliver_len     = q_entry.len;
                        if (q_entry.data_ack || piggy_reg)
                        begin
                            ack_owed_next = 1'b1;
                        end
                    end
                    else if (q_entry.sound && (q_entry.data_ack || piggy_reg))
                    begin
                        ack_owed_next = 1'b0;
                        send_ack      = 1'b1;
                    end
                    // plain data without piggybacking is always acked, corrupt too
                    if (!q_entry.data_ack && !piggy_reg)
                    begin
                        send_ack = 1'b1;
                    end
                end
                if (send_ack)
                begin
                    res_next.tx_valid   = 1'b1;
                    res_next.tx_kind    = KIND_ACK;
                    res_next.tx_seq     = 10'd0;
                    res_next.tx_ack     = {9'd0, recv_ack_next};
                    res_next.tx_crc     = q_entry.base_crc
                                        ^ (recv_ack_next ? CRC_ACK_TERM : 3'b000);
                    res_next.tx_payload = q_entry.payload;
                    res_next.tx_len     = q_entry.len;
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piggy_reg         <= 1'b0;
            ready_to_send_reg <= 1'b1;
            send_seq_reg      <= 1'b0;
            recv_ack_reg      <= 1'b1;
            ack_owed_reg      <= 1'b0;
            held_kind_reg     <= KIND_DATA;
            held_seq_reg      <= 1'b0;
            held_ack_reg      <= 1'b0;
            held_crc_reg      <= 3'd0;
            held_payload_reg  <= 24'd0;
            held_len_reg      <= 2'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                piggy_reg <= cfg_wr_data;
            end
            if (load)
            begin
                ready_to_send_reg <= ready_to_send_next;
                send_seq_reg      <= send_seq_next;
                recv_ack_reg      <= recv_ack_next;
                ack_owed_reg      <= ack_owed_next;
                held_kind_reg     <= held_kind_next;
                held_seq_reg      <= held_seq_next;
                held_ack_reg      <= held_ack_next;
                held_crc_reg      <= held_crc_next;
                held_payload_reg  <= held_payload_next;
                held_len_reg      <= held_len_next;
                out_valid_reg     <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.tx_valid        = out_reg.tx_valid;
    assign rsp.tx_kind         = out_reg.tx_kind;
    assign rsp.tx_seq          = out_reg.tx_seq;
    assign rsp.tx_ack          = out_reg.tx_ack;
    assign rsp.tx_crc          = out_reg.tx_crc;
    assign rsp.tx_payload      = out_reg.tx_payload;
    assign rsp.tx_len          = out_reg.tx_len;
    assign rsp.deliver_valid   = out_reg.deliver_valid;
    assign rsp.deliver_payload = out_reg.deliver_payload;
    assign rsp.deliver_len     = out_reg.deliver_len;
    assign rsp.timer_cmd       = out_reg.timer_cmd;

    a_send_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (load && q_entry.op == OP_SEND && res_next.timer_cmd == TMR_START)
        |=> !ready_to_send_reg)
        else $error("send did not clear ready to send");

    a_stop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_next.timer_cmd == TMR_STOP) |=> ready_to_send_reg)
        else $error("timer stop without ready to send");

    a_deliver_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_next.deliver_valid) |=> (recv_ack_reg != $past(recv_ack_reg)))
        else $error("delivery without ack bit toggle");

endmodule

`default_nettype wire

FILE: sv/stop_and_wait_arq_crc3_entity_top.sv
`default_nettype none

// channel | dir | handshake        | word
// req     | in  | valid/ready      | request: type, payload, len, rx frame fields
// rsp     | out | valid/ready      | result: tx frame, delivery, timer command
// cfg     | in  | cfg_wr_en strobe | piggyback enable
//
// one word per cycle sustained while rsp takes results; a result passes through a queue entry,
// then the output register, and holds on rsp until taken
// reset sets the protocol flags to their start values and clears the held frame; the queue comes up empty
// a stalled result holds in the output register while the queue takes up to
// QUEUE_DEPTH more words, then req.ready drops

module stop_and_wait_arq_crc3_entity_top
    import sawc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    sawc_req_if.sink   req,
    sawc_rsp_if.source rsp
);

    entry_t push_entry;
    entry_t pop_entry;
    logic   q_push;
    logic   q_not_full;
    logic   q_pop;
    logic   q_not_empty;

    sawc_front u_front (
        .req     (req),
        .q_ready (q_not_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    sawc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (push_entry),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .dout      (pop_entry),
        .not_empty (q_not_empty)
    );

    sawc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire
